/* hdl/wesm_pkg.sv */
// ---------------------------------------------------------------------------
// wesm_pkg: wheel encoder speed meter package
// Field widths, constants, operation and register codes, shared structs.
// ---------------------------------------------------------------------------
package wesm_pkg;

  localparam int NUM_CHANNELS = 2;

  localparam int OP_W     = 2;
  localparam int CH_W     = 1;
  localparam int TS_W     = 32;
  localparam int COUNT_W  = 32;
  localparam int DIST_W   = 48;
  localparam int SPEED_W  = 16;
  localparam int DPP_W    = 24;
  localparam int TMO_W    = 32;
  localparam int PERIOD_W = 20;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // speed division: numerator dpp * 1e6, divisor period * 256
  localparam int NUM_W     = DPP_W + PERIOD_W;
  localparam int DEN_W     = PERIOD_W + 8;
  localparam int QUO_W     = SPEED_W;
  localparam int DIV_CNT_W = $clog2(QUO_W + 2);
  localparam int LIM_W     = TMO_W + 11;

  localparam logic [TS_W-1:0]     PERIOD_MIN_US = TS_W'(1000);
  localparam logic [TS_W-1:0]     PERIOD_MAX_US = TS_W'(1000000);
  localparam logic [NUM_W-1:0]    USEC_PER_SEC  = NUM_W'(1000000);
  localparam logic [LIM_W-1:0]    USEC_PER_MS   = LIM_W'(1000);
  localparam logic [SPEED_W-1:0]  SPEED_CAP_Q8  = SPEED_W'(51200);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = PERIOD_W'(100000);
  localparam logic [TMO_W-1:0]    TMO_RESET     = TMO_W'(100);

  typedef enum logic [OP_W-1:0] {
    OP_EDGE  = 2'd0,
    OP_READ  = 2'd1,
    OP_RESET = 2'd2
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TIMEOUT  = 2'd1;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [DIST_W-1:0]   travel;
    logic [PERIOD_W-1:0] period;
    logic [TS_W-1:0]     last;
  } chan_rd_t;

  typedef struct packed {
    logic               done;
    logic               busy;
    logic               ovf;
    logic [QUO_W-1:0]   quo;
  } div_res_t;

endpackage

/* hdl/wesm_in_if.sv */
// ---------------------------------------------------------------------------
// wesm_in_if: input item channel
// Valid/ready channel carrying operation, channel and timestamp.
// ---------------------------------------------------------------------------
interface wesm_in_if import wesm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [CH_W-1:0] channel;
  logic [TS_W-1:0] timestamp_us;

  modport source (output valid, operation, channel, timestamp_us, input ready);
  modport sink   (input valid, operation, channel, timestamp_us, output ready);
endinterface

/* hdl/wesm_out_if.sv */
// ---------------------------------------------------------------------------
// wesm_out_if: result channel
// Valid/ready channel carrying count, distance and the two speeds.
// ---------------------------------------------------------------------------
interface wesm_out_if import wesm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] pulse_total;
  logic [DIST_W-1:0]  distance_q16;
  logic [SPEED_W-1:0] speed_q8;
  logic [SPEED_W-1:0] gated_speed_q8;

  modport source (output valid, pulse_total, distance_q16, speed_q8, gated_speed_q8,
                  input ready);
  modport sink   (input valid, pulse_total, distance_q16, speed_q8, gated_speed_q8,
                  output ready);
endinterface

/* hdl/wesm_cfg_if.sv */
// ---------------------------------------------------------------------------
// wesm_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface wesm_cfg_if import wesm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/wheel_encoder_speed_meter.sv */
// Each input item passes through the update, load, divide and finish steps before its result is registered.
// A new item is accepted only while the sequencer is idle; the 17-step serial speed divider dominates this.
// The output register frees the result side: a waiting result stalls only the final step.
// Reset (rst_n low, synchronous) clears all channel state at once: counts, distance and
// last time to zero, stored period to 100000 us; distance per pulse 0, timeout 100 ms.
// ---------------------------------------------------------------------------
// wheel_encoder_speed_meter: two-channel wheel encoder speed meter
// Counts edges, accumulates distance and derives period-based speed with a
// bit-serial divider, plus a timeout-gated copy of the speed.
// ---------------------------------------------------------------------------
module wheel_encoder_speed_meter import wesm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  wesm_in_if.sink     in_ch,
  wesm_out_if.source  out_ch,
  wesm_cfg_if.sink    cfg_ch
);

  // Sequencer: take item, update channel state, load divider, divide, finish.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_UPD  = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [DPP_W-1:0] dpp_r;
  logic [TMO_W-1:0] tmo_r;

  // captured item
  logic [OP_W-1:0] op_r;
  logic [CH_W-1:0] ch_r;
  logic [TS_W-1:0] ts_r;

  // working values, loaded after the state update
  logic [COUNT_W-1:0] count_r;
  logic [DIST_W-1:0]  dist_r;
  logic [TS_W-1:0]    elapsed_r;
  logic [LIM_W-1:0]   lim_r;
  logic               zero_r;
  logic               oor_r;

  // output register
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic [SPEED_W-1:0] out_speed_r;
  logic [SPEED_W-1:0] out_gated_r;

  chan_rd_t         rd;
  div_res_t         div_res;
  logic [NUM_W-1:0] num;
  logic             in_xfer;
  logic             out_free;
  logic [SPEED_W-1:0] speed;
  logic             expired;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  // config writes; indices off the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpp_r <= '0;
      tmo_r <= TMO_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_DIST_PER_PULSE) dpp_r <= cfg_ch.data[DPP_W-1:0];
      if (cfg_ch.index == CFG_SPEED_TIMEOUT)  tmo_r <= cfg_ch.data[TMO_W-1:0];
    end
  end

  wesm_chan u_chan (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (state_r == ST_UPD),
    .op    (op_r),
    .ch    (ch_r),
    .ts    (ts_r),
    .dpp   (dpp_r),
    .rd    (rd)
  );

  // numerator dpp * 1e6: constant multiply, registered inside the divider
  assign num = NUM_W'(dpp_r) * USEC_PER_SEC;

  wesm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == ST_LOAD),
    .num    (num),
    .period (rd.period),
    .res    (div_res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (div_res.done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r <= in_ch.operation;
      ch_r <= in_ch.channel;
      ts_r <= in_ch.timestamp_us;
    end
  end

  // Load step: channel state is already updated. The timeout test
  // floor(elapsed / 1000) > T is rewritten as elapsed >= 1000 * (T + 1),
  // so no division by 1000 is needed.
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      count_r   <= rd.count;
      dist_r    <= rd.travel;
      elapsed_r <= ts_r - rd.last;
      lim_r     <= (LIM_W'(tmo_r) + LIM_W'(1)) * USEC_PER_MS;
      zero_r    <= rd.period <= PERIOD_MIN_US[PERIOD_W-1:0];
      oor_r     <= !(int'(ch_r) < NUM_CHANNELS);
    end
  end

  // speed: zero for short or cleared periods, capped at 200 cm/s
  always_comb begin
    priority if (zero_r)                               speed = '0;
    else if (div_res.ovf || div_res.quo > SPEED_CAP_Q8) speed = SPEED_CAP_Q8;
    else                                               speed = div_res.quo;
  end

  assign expired = LIM_W'(elapsed_r) >= lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      // channel out of range: every field reads zero
      out_count_r <= oor_r ? '0 : count_r;
      out_dist_r  <= oor_r ? '0 : dist_r;
      out_speed_r <= oor_r ? '0 : speed;
      out_gated_r <= (oor_r || expired) ? '0 : speed;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pulse_total    = out_count_r;
  assign out_ch.distance_q16   = out_dist_r;
  assign out_ch.speed_q8       = out_speed_r;
  assign out_ch.gated_speed_q8 = out_gated_r;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide step");

  a_div_idle_on_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> !div_res.busy)
    else $error("input transfer while the divider is running");

  a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_speed_r <= SPEED_CAP_Q8)
    else $error("speed above cap");

  a_gated_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_gated_r == '0) || (out_gated_r == out_speed_r))
    else $error("gated speed neither zero nor speed");

  a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && out_free |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished result not loaded into output register");
`endif

endmodule

/* hdl/wesm_chan.sv */
// ---------------------------------------------------------------------------
// wesm_chan: per-channel encoder state
// Edge count, last edge time, stored period and distance, one set per channel.
// ---------------------------------------------------------------------------
module wesm_chan import wesm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             upd,
  input  logic [OP_W-1:0]  op,
  input  logic [CH_W-1:0]  ch,
  input  logic [TS_W-1:0]  ts,
  input  logic [DPP_W-1:0] dpp,
  output chan_rd_t         rd
);

  logic [COUNT_W-1:0]  count_r  [NUM_CHANNELS];
  logic [TS_W-1:0]     last_r   [NUM_CHANNELS];
  logic [PERIOD_W-1:0] period_r [NUM_CHANNELS];
  logic [DIST_W-1:0]   dist_r   [NUM_CHANNELS];

  logic              ch_ok;
  logic [TS_W-1:0]   period;
  logic              in_win;
  logic [DIST_W:0]   dsum;
  logic [DIST_W-1:0] dsat;

  assign ch_ok  = int'(ch) < NUM_CHANNELS;
  assign period = ts - last_r[ch];
  assign in_win = (last_r[ch] != '0) && (period > PERIOD_MIN_US) && (period < PERIOD_MAX_US);
  assign dsum   = {1'b0, dist_r[ch]} + (DIST_W + 1)'(dpp);
  assign dsat   = dsum[DIST_W] ? '1 : dsum[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        count_r[i]  <= '0;
        last_r[i]   <= '0;
        period_r[i] <= PERIOD_RESET;
        dist_r[i]   <= '0;
      end
    end else if (upd && ch_ok) begin
      unique case (op)
        OP_EDGE: begin
          count_r[ch] <= count_r[ch] + COUNT_W'(1);
          last_r[ch]  <= ts;
          if (in_win) begin
            period_r[ch] <= period[PERIOD_W-1:0];
            dist_r[ch]   <= dsat;
          end
        end
        OP_RESET: begin
          count_r[ch]  <= '0;
          last_r[ch]   <= ts;
          period_r[ch] <= '0;
          dist_r[ch]   <= '0;
        end
        default: ;  // read only, spare code
      endcase
    end
  end

  assign rd.count  = count_r[ch];
  assign rd.travel = dist_r[ch];
  assign rd.period = period_r[ch];
  assign rd.last   = last_r[ch];

endmodule

/* hdl/wesm_div.sv */
// ---------------------------------------------------------------------------
// wesm_div: bit-serial speed divider
// Restoring division, one quotient bit per cycle, with 16-bit overflow flag.
// ---------------------------------------------------------------------------
module wesm_div import wesm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [PERIOD_W-1:0] period,
  output div_res_t            res
);

  localparam logic [DIV_CNT_W-1:0] CNT_FIRST = DIV_CNT_W'(QUO_W + 1);
  localparam logic [DIV_CNT_W-1:0] CNT_LAST  = DIV_CNT_W'(1);

  logic [DEN_W:0]         rem_r, rem_nxt;
  logic [QUO_W-1:0]       lo_r, lo_nxt;
  logic [QUO_W-1:0]       quo_r, quo_nxt;
  logic [DEN_W-1:0]       den_r;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [DEN_W:0]         trial;
  logic                   ge;

  assign trial = {rem_r[DEN_W-1:0], lo_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    if (busy_r) begin
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == CNT_FIRST) begin
        // quotient of 2^16 or more: high part already reaches the divisor
        ovf_nxt = rem_r[DEN_W-1:0] >= den_r;
      end else begin
        rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
        lo_nxt  = {lo_r[QUO_W-2:0], 1'b0};
        quo_nxt = {quo_r[QUO_W-2:0], ge};
        if (cnt_r == CNT_LAST) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_FIRST;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num[NUM_W-1:QUO_W]};
      lo_r  <= num[QUO_W-1:0];
      quo_r <= '0;
      den_r <= {period, 8'b0};
      ovf_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
      quo_r <= quo_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign res.done = done_r;
  assign res.busy = busy_r;
  assign res.ovf  = ovf_r;
  assign res.quo  = quo_r;

endmodule
